/* src/dfkt_pkg.sv */
// ----------------------------------------------------------------------------
// dfkt_pkg: shared definitions for the key table
// Field widths, status and operation codes and default sizing.
// ----------------------------------------------------------------------------
package dfkt_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int KEY_W           = 32;
	localparam int STATUS_W        = 2;
	localparam int COUNT_OUT_W     = 5;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED    = 2'd0,
		ST_PRESENT  = 2'd1,
		ST_REMOVED  = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic {
		OP_ADD    = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

endpackage

/* src/dfkt_if.sv */
// ----------------------------------------------------------------------------
// dfkt_if: request and response channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dfkt_req_if;
	import dfkt_pkg::*;

	logic             valid;
	logic             ready;
	logic             operation;
	logic [KEY_W-1:0] key;

	modport source (output valid, output operation, output key, input ready);
	modport sink   (input valid, input operation, input key, output ready);
endinterface

interface dfkt_rsp_if;
	import dfkt_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [STATUS_W-1:0]    status;
	logic                   evicted;
	logic [KEY_W-1:0]       evicted_key;
	logic [COUNT_OUT_W-1:0] entry_count;

	modport source (output valid, output status, output evicted, output evicted_key,
		output entry_count, input ready);
	modport sink   (input valid, input status, input evicted, input evicted_key,
		input entry_count, output ready);
endinterface

/* src/dfkt_ram.sv */
// ----------------------------------------------------------------------------
// dfkt_ram: key storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dfkt_ram #(
	parameter int DEPTH  = dfkt_pkg::MAX_ENTRIES_DEF,
	parameter int ADDR_W = 4,
	parameter int DATA_W = dfkt_pkg::KEY_W
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);
	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end
endmodule

/* src/dfkt_ctrl.sv */
// ----------------------------------------------------------------------------
// dfkt_ctrl: table sequencer
// Scans the ring of keys one entry a cycle through a shared comparator,
// appends, evicts and closes gaps, and holds the response register.
// ----------------------------------------------------------------------------
module dfkt_ctrl #(
	parameter int MAX_ENTRIES = dfkt_pkg::MAX_ENTRIES_DEF,
	parameter int IDX_W       = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	dfkt_req_if.sink                   req,
	dfkt_rsp_if.source                 rsp,
	output logic                       ram_we,
	output logic [IDX_W-1:0]           ram_waddr,
	output logic [dfkt_pkg::KEY_W-1:0] ram_wdata,
	output logic [IDX_W-1:0]           ram_raddr,
	input  logic [dfkt_pkg::KEY_W-1:0] ram_rdata
);
	import dfkt_pkg::*;

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [CNT_W:0] MAX_X = (CNT_W + 1)'(MAX_ENTRIES);
	localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_EVICT,
		S_SHIFT,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] cmp_idx_q;
	logic             chk_q;
	logic             op_q;
	logic [KEY_W-1:0] key_q;
	status_t          status_q;
	logic             ev_q;
	logic [KEY_W-1:0] ev_key_q;

	logic                   out_valid_q;
	status_t                out_status_q;
	logic                   out_ev_q;
	logic [KEY_W-1:0]       out_ev_key_q;
	logic [COUNT_OUT_W-1:0] out_count_q;

	logic             hit;
	logic [IDX_W-1:0] head_next;
	logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

	function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
		input logic [CNT_W-1:0] pos);
		logic [CNT_W:0] sum;
		sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, pos};
		if (sum >= MAX_X) begin
			sum = sum - MAX_X;
		end
		return sum[IDX_W-1:0];
	endfunction

	assign hit       = chk_q && (ram_rdata == key_q);
	assign head_next = (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
	assign count_ext = {{COUNT_OUT_W{1'b0}}, count_q};
	assign ram_raddr = phys(head_q, idx_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = phys(head_q, count_q);
		ram_wdata = key_q;
		case (state_q)
			S_SCAN: begin
				if (!hit && idx_q == count_q && op_q == OP_ADD) begin
					ram_we = 1'b1;
				end
			end
			S_SHIFT: begin
				ram_waddr = phys(head_q, cmp_idx_q - CNT_W'(1));
				ram_wdata = ram_rdata;
				ram_we    = chk_q;
			end
			default: begin
			end
		endcase
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.evicted     = out_ev_q;
	assign rsp.evicted_key = out_ev_key_q;
	assign rsp.entry_count = out_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			head_q       <= '0;
			idx_q        <= '0;
			cmp_idx_q    <= '0;
			chk_q        <= 1'b0;
			op_q         <= 1'b0;
			key_q        <= '0;
			status_q     <= ST_ADDED;
			ev_q         <= 1'b0;
			ev_key_q     <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_ADDED;
			out_ev_q     <= 1'b0;
			out_ev_key_q <= '0;
			out_count_q  <= '0;
		end else begin
			if (out_valid_q && rsp.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q     <= req.operation;
						key_q    <= req.key;
						idx_q    <= '0;
						chk_q    <= 1'b0;
						ev_q     <= 1'b0;
						ev_key_q <= '0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						chk_q <= 1'b0;
						if (op_q == OP_ADD) begin
							status_q <= ST_PRESENT;
							state_q  <= S_DONE;
						end else begin
							status_q <= ST_REMOVED;
							idx_q    <= cmp_idx_q + CNT_W'(1);
							state_q  <= S_SHIFT;
						end
					end else if (idx_q == count_q) begin
						chk_q <= 1'b0;
						if (op_q == OP_ADD) begin
							status_q <= ST_ADDED;
							if (count_q == MAX_C) begin
								head_q  <= head_next;
								ev_q    <= 1'b1;
								state_q <= S_EVICT;
							end else begin
								count_q <= count_q + CNT_W'(1);
								state_q <= S_DONE;
							end
						end else begin
							status_q <= ST_NOTFOUND;
							state_q  <= S_DONE;
						end
					end else begin
						cmp_idx_q <= idx_q;
						chk_q     <= 1'b1;
						idx_q     <= idx_q + CNT_W'(1);
					end
				end
				S_EVICT: begin
					ev_key_q <= ram_rdata;
					state_q  <= S_DONE;
				end
				S_SHIFT: begin
					if (idx_q == count_q) begin
						chk_q   <= 1'b0;
						count_q <= count_q - CNT_W'(1);
						state_q <= S_DONE;
					end else begin
						cmp_idx_q <= idx_q;
						chk_q     <= 1'b1;
						idx_q     <= idx_q + CNT_W'(1);
					end
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_ev_q     <= ev_q;
						out_ev_key_q <= ev_key_q;
						out_count_q  <= count_ext[COUNT_OUT_W-1:0];
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_C)
		else $error("Entry count exceeds the table size.");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == $past(count_q) || count_q == $past(count_q) + CNT_W'(1) ||
		count_q == $past(count_q) - CNT_W'(1))
		else $error("Entry count moved by more than one in a cycle.");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= LAST_IDX)
		else $error("Head pointer left the table.");

	a_evict_added: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_ev_q |-> out_status_q == ST_ADDED &&
		out_count_q == COUNT_OUT_W'(MAX_ENTRIES))
		else $error("Eviction reported without an add to a full table.");

	a_evict_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ev_q |-> out_ev_key_q == '0)
		else $error("Evicted key is nonzero without an eviction.");
`endif
endmodule

/* src/dedup_fifo_key_table.sv */
// ----------------------------------------------------------------------------
// dedup_fifo_key_table: ordered set of distinct keys with oldest-first eviction
// Adds a key if absent, evicting the oldest entry when full, or removes a key.
//
// Channel  Direction  Payload
// req      in         operation, key
// rsp      out        status, evicted, evicted_key, entry_count
//
// A request scans the entries in order through the single key comparator until
// the match or the end of the table. An eviction adds a state that captures the
// evicted oldest key; a removal moves each younger entry down through the storage
// read and write ports. Reset is asynchronous; the storage needs no clearing
// pass after it. A stalled response holds in its register while the next
// request is taken.
// ----------------------------------------------------------------------------
module dedup_fifo_key_table #(
	parameter int MAX_ENTRIES = dfkt_pkg::MAX_ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	dfkt_req_if.sink   req,
	dfkt_rsp_if.source rsp
);
	import dfkt_pkg::*;

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [KEY_W-1:0] ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	logic [KEY_W-1:0] ram_rdata;

	dfkt_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.IDX_W      (IDX_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	dfkt_ram #(
		.DEPTH (MAX_ENTRIES),
		.ADDR_W(IDX_W),
		.DATA_W(KEY_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);
endmodule

/* dv/tb_dedup_fifo_key_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dedup_fifo_key_table: self-checking bench for the key table
// Requests come from a queue: a directed opening, then random add and remove
// traffic over a small key pool mixed with fully random keys. The sender
// works in bursts and the receiver stalls on a rotating pattern. Every
// accepted request updates a copy of the ordered key list, and the response
// it must cause is checked field by field against the block's responses.
// ----------------------------------------------------------------------------
module tb_dedup_fifo_key_table;
	import dfkt_pkg::*;

	localparam int MAX_ENTRIES = MAX_ENTRIES_DEF;
	localparam int IDLE_LIMIT  = 4000;
	localparam int RANDOM_REQS = 400;
	localparam int POOL_SIZE   = 24;

	typedef struct {
		bit               hold;
		op_t              operation;
		logic [KEY_W-1:0] key;
	} key_req_t;

	typedef struct {
		status_t                status;
		logic                   evicted;
		logic [KEY_W-1:0]       evicted_key;
		logic [COUNT_OUT_W-1:0] entry_count;
	} key_rsp_t;

	logic clk;
	logic arst_n;

	dfkt_req_if req ();
	dfkt_rsp_if rsp ();

	dedup_fifo_key_table #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	key_req_t         pending_req_q[$];
	key_rsp_t         expected_rsp_q[$];
	logic [KEY_W-1:0] key_order_q[$];
	logic [KEY_W-1:0] key_pool[POOL_SIZE];
	int               burst_left;
	int               gap_left;
	int               stall_tick;
	logic [31:0]      ready_pattern;
	int               idle_cycles;
	int               fail_cnt;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// The list is kept oldest first, exactly as the block orders its entries.
	function automatic key_rsp_t apply_request(op_t operation, logic [KEY_W-1:0] key);
		key_rsp_t r;
		int       pos;
		r.status      = ST_ADDED;
		r.evicted     = 1'b0;
		r.evicted_key = '0;
		pos           = -1;
		foreach (key_order_q[i])
			if (pos < 0 && key_order_q[i] == key)
				pos = i;
		if (operation == OP_ADD) begin
			if (pos >= 0) begin
				r.status = ST_PRESENT;
			end else begin
				if (key_order_q.size() >= MAX_ENTRIES) begin
					r.evicted     = 1'b1;
					r.evicted_key = key_order_q.pop_front();
				end
				key_order_q.insert(key_order_q.size(), key);
			end
		end else if (pos >= 0) begin
			key_order_q.delete(pos);
			r.status = ST_REMOVED;
		end else begin
			r.status = ST_NOTFOUND;
		end
		r.entry_count = COUNT_OUT_W'(key_order_q.size());
		return r;
	endfunction

	task automatic queue_request(op_t operation, logic [KEY_W-1:0] key);
		key_req_t item;
		item.hold      = 1'b0;
		item.operation = operation;
		item.key       = key;
		pending_req_q.insert(pending_req_q.size(), item);
	endtask

	task automatic queue_hold();
		key_req_t item;
		item.hold      = 1'b1;
		item.operation = OP_ADD;
		item.key       = '0;
		pending_req_q.insert(pending_req_q.size(), item);
	endtask

	always @(posedge clk) begin : req_driver
		key_req_t item;
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			if (req.valid && req.ready)
				expected_rsp_q.insert(expected_rsp_q.size(),
					apply_request(op_t'(req.operation), req.key));
			if (!req.valid || req.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req.valid <= 1'b0;
				end else if (pending_req_q.size() == 0) begin
					req.valid <= 1'b0;
				end else if (pending_req_q[0].hold) begin
					req.valid <= 1'b0;
					if (expected_rsp_q.size() == 0)
						void'(pending_req_q.pop_front());
				end else begin
					item = pending_req_q.pop_front();
					req.valid     <= 1'b1;
					req.operation <= item.operation;
					req.key       <= item.key;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 12);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	always @(posedge clk) begin : rsp_monitor
		key_rsp_t exp_rsp;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp_q.size() == 0) begin
					$error("response transfer with no request outstanding");
					fail_cnt++;
				end else begin
					exp_rsp = expected_rsp_q.pop_front();
					if (rsp.status !== exp_rsp.status) begin
						$error("status: expected %0d, actual %0d", exp_rsp.status, rsp.status);
						fail_cnt++;
					end
					if (rsp.evicted !== exp_rsp.evicted) begin
						$error("evicted: expected %0d, actual %0d", exp_rsp.evicted,
							rsp.evicted);
						fail_cnt++;
					end
					if (rsp.evicted_key !== exp_rsp.evicted_key) begin
						$error("evicted_key: expected %h, actual %h", exp_rsp.evicted_key,
							rsp.evicted_key);
						fail_cnt++;
					end
					if (rsp.entry_count !== exp_rsp.entry_count) begin
						$error("entry_count: expected %0d, actual %0d", exp_rsp.entry_count,
							rsp.entry_count);
						fail_cnt++;
					end
				end
			end
			stall_tick++;
			if (stall_tick >= 96) begin
				stall_tick = 0;
				case ($urandom_range(0, 3))
					0: begin
						ready_pattern = '1;
					end
					1: begin
						ready_pattern = $urandom | 32'h1;
					end
					default: begin
						ready_pattern = ($urandom & $urandom) | 32'h1;
					end
				endcase
			end
			rsp.ready     <= ready_pattern[0];
			ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
		end
	end

	always @(posedge clk) begin : watchdog
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int pick;
		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.operation = OP_ADD;
		req.key       = '0;
		rsp.ready     = 1'b0;
		burst_left    = 0;
		gap_left      = 0;
		stall_tick    = 0;
		ready_pattern = '1;
		idle_cycles   = 0;
		fail_cnt      = 0;

		// Opening sequence: empty table, the key extremes, duplicates, a full
		// table with eviction, and removals from the middle and the young end.
		queue_request(OP_REMOVE, 32'h0000_0000);
		queue_request(OP_ADD, 32'h0000_0000);
		queue_request(OP_ADD, 32'hFFFF_FFFF);
		queue_request(OP_ADD, 32'h0000_0000);
		queue_request(OP_REMOVE, 32'h1234_5678);
		queue_request(OP_REMOVE, 32'h0000_0000);
		for (int i = 1; i < MAX_ENTRIES; i++)
			queue_request(OP_ADD, 32'h1000_0000 + i * 32'h0101_0101);
		queue_request(OP_ADD, 32'hA5A5_A5A5);
		queue_request(OP_ADD, 32'h1000_0000 + 5 * 32'h0101_0101);
		queue_request(OP_REMOVE, 32'h1000_0000 + 8 * 32'h0101_0101);
		queue_request(OP_REMOVE, 32'hA5A5_A5A5);
		queue_hold();

		foreach (key_pool[i])
			key_pool[i] = $urandom;
		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (n == RANDOM_REQS / 2)
				queue_hold();
			pick = (n < RANDOM_REQS / 2) ? POOL_SIZE - 1 : POOL_SIZE / 2 - 1;
			queue_request(($urandom_range(0, 9) < 6) ? OP_ADD : OP_REMOVE,
				($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, pick)] : $urandom);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_req_q.size() != 0 || req.valid || expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);

		if (fail_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* files.f */
src/dfkt_pkg.sv
src/dfkt_if.sv
src/dfkt_ram.sv
src/dfkt_ctrl.sv
src/dedup_fifo_key_table.sv
dv/tb_dedup_fifo_key_table.sv
